### rtl/fsvl_pkg.sv
`timescale 1ns / 1ps

package fsvl_pkg;

  localparam int unsigned NUM_STEPS = 32;
  localparam int unsigned RAD_W     = 64;
  localparam int unsigned VAL_W     = 32;

  localparam logic CMD_SQRT   = 1'b0;
  localparam logic CMD_LENGTH = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [RAD_W-1:0] rad;
    logic [RAD_W-1:0] acc;
  } fsvl_cell_t;

  typedef struct packed {
    logic             valid;
    logic             cmd;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
  } fsvl_req_t;

endpackage

### rtl/fsvl_prep.sv
`timescale 1ns / 1ps

module fsvl_prep
  import fsvl_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  fsvl_req_t  req,
  output fsvl_cell_t cell_out
);

  logic             v1_r, v2_r, v3_r;
  logic             cmd1_r, cmd2_r;
  logic [VAL_W-1:0] mx_r, my_r;
  logic [RAD_W-1:0] sq_rad1_r, sq_rad2_r;
  logic [RAD_W-1:0] px_r, py_r;
  logic [RAD_W-1:0] rad3_r;

  logic [VAL_W-1:0] mx_nxt, my_nxt;
  logic [RAD_W-1:0] sq_rad_nxt;
  logic [RAD_W-1:0] rad3_nxt;

  // magnitudes, most negative value maps to 2^31 exactly
  always_comb begin
    mx_nxt = req.first_value[VAL_W-1] ? (VAL_W'(0) - req.first_value) : req.first_value;
    my_nxt = req.second_value[VAL_W-1] ? (VAL_W'(0) - req.second_value) : req.second_value;
    if (req.first_value == '0 || req.first_value[VAL_W-1]) begin
      sq_rad_nxt = '0;
    end else begin
      sq_rad_nxt = {{(RAD_W-VAL_W){1'b0}}, req.first_value} << (FRAC_BITS & 31);
    end
  end

  assign rad3_nxt = (cmd2_r == CMD_LENGTH) ? (px_r + py_r) : sq_rad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd1_r    <= req.cmd;
      mx_r      <= mx_nxt;
      my_r      <= my_nxt;
      sq_rad1_r <= sq_rad_nxt;
      cmd2_r    <= cmd1_r;
      px_r      <= RAD_W'(mx_r) * RAD_W'(mx_r);
      py_r      <= RAD_W'(my_r) * RAD_W'(my_r);
      sq_rad2_r <= sq_rad1_r;
      rad3_r    <= rad3_nxt;
    end
  end

  assign cell_out.valid = v3_r;
  assign cell_out.rad   = rad3_r;
  assign cell_out.acc   = '0;

endmodule

### rtl/fsvl_cell.sv
`timescale 1ns / 1ps

module fsvl_cell
  import fsvl_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  fsvl_cell_t cell_in,
  output fsvl_cell_t cell_out
);

  localparam logic [RAD_W-1:0] WEIGHT = RAD_W'(1) << (RAD_W - 2 - 2 * STEP);

  logic             valid_r;
  logic [RAD_W-1:0] rad_r, acc_r;
  logic [RAD_W-1:0] trial;
  logic [RAD_W-1:0] rad_nxt, acc_nxt;

  // one bit of the floor root, from one base-4 digit of the radicand
  always_comb begin
    trial = cell_in.acc + WEIGHT;
    if (cell_in.rad >= trial) begin
      rad_nxt = cell_in.rad - trial;
      acc_nxt = (cell_in.acc >> 1) + WEIGHT;
    end else begin
      rad_nxt = cell_in.rad;
      acc_nxt = cell_in.acc >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rad_r <= rad_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign cell_out.valid = valid_r;
  assign cell_out.rad   = rad_r;
  assign cell_out.acc   = acc_r;

endmodule

### rtl/fixed_sqrt_and_vector_length.sv
`timescale 1ns / 1ps
// channel  direction  tdata                                   tuser
// in_      slave      [31:0] first_value, [63:32] second_value  cmd
// out_     master     [31:0] root_value                        wrapped
//
// one request per cycle unless out_tready stalls; 3 radicand stages (magnitude,
// squares, sum) then a row of 32 digit cells, the last cell is the output register
// synchronous active-low reset empties every stage and the input skid register
// when a result waits on out_tready the whole row holds; one more request is
// taken into the input skid register meanwhile

module fixed_sqrt_and_vector_length
  import fsvl_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_value, second_value
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // root_value
  output logic        out_tuser   // wrapped
);

  logic       advance;
  logic       in_acc;
  logic       skid_valid_r;
  fsvl_req_t  skid_r;
  fsvl_req_t  head;
  fsvl_cell_t chain [NUM_STEPS+1];

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (skid_valid_r) begin
      head = skid_r;
    end else begin
      head.valid        = in_acc;
      head.cmd          = in_tuser;
      head.first_value  = in_tdata[31:0];
      head.second_value = in_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (advance) begin
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!advance && in_acc) begin
      skid_r.valid        <= 1'b1;
      skid_r.cmd          <= in_tuser;
      skid_r.first_value  <= in_tdata[31:0];
      skid_r.second_value <= in_tdata[63:32];
    end
  end

  fsvl_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (head),
    .cell_out(chain[0])
  );

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_cell
    fsvl_cell #(
      .STEP(g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .cell_in (chain[g]),
      .cell_out(chain[g+1])
    );
  end

  assign out_tvalid = chain[NUM_STEPS].valid;
  assign out_tdata  = chain[NUM_STEPS].acc[VAL_W-1:0];
  assign out_tuser  = chain[NUM_STEPS].acc[VAL_W-1];

`ifndef NO_ASSERTIONS
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && advance |=> !skid_valid_r)
    else $error("skid register not drained");

  a_wrap_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == out_tdata[31]))
    else $error("wrapped flag disagrees with root");

  a_row_moves: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_tvalid == $past(chain[NUM_STEPS-1].valid)))
    else $error("cell row lost or invented a request");

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chain[NUM_STEPS].acc[RAD_W-1:VAL_W] == '0))
    else $error("root exceeds 32 bits");
`endif

endmodule
